// ===== rtl/prba_pkg.sv =====
package prba_pkg;

	localparam int ADDR_W      = 32;
	localparam int FRAME_W     = 20;
	localparam int COUNT_W     = 13;
	localparam int COUNT_RESET = 4096;
	localparam int PAGE_SHIFT  = 12;
	localparam int WORD_BITS   = 64;
	localparam int WB_W        = 6;
	localparam int STEP_BITS   = 8;
	localparam int SB_W        = 3;
	localparam int IN_DATA_W   = 48;
	localparam int OUT_DATA_W  = 40;

	typedef enum logic {
		KIND_ALLOC = 1'b0,
		KIND_FREE  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOSPACE  = 2'd1,
		ST_BADCOUNT = 2'd2,
		ST_OUTSIDE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_POOL0_BASE  = 2'd0,
		REG_POOL1_BASE  = 2'd1,
		REG_POOL0_COUNT = 2'd2,
		REG_POOL1_COUNT = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic               found;
		logic [SB_W-1:0]    pos;
		logic [COUNT_W-1:0] run;
	} scan_res_t;

endpackage

// ===== rtl/prba_ram.sv =====
module prba_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ===== rtl/prba_scan.sv =====
module prba_scan (
	input  logic [prba_pkg::STEP_BITS-1:0] lane_bits,
	input  logic [prba_pkg::STEP_BITS-1:0] lane_en,
	input  logic [prba_pkg::COUNT_W-1:0]   run_in,
	input  logic [prba_pkg::COUNT_W-1:0]   count,
	output prba_pkg::scan_res_t            res
);

	always_comb begin
		logic [prba_pkg::COUNT_W-1:0] run;
		logic                         found;
		logic [prba_pkg::SB_W-1:0]    pos;
		run   = run_in;
		found = 1'b0;
		pos   = '0;
		for (int k = 0; k < prba_pkg::STEP_BITS; k++) begin
			if (lane_en[k] && !found) begin
				if (lane_bits[k]) begin
					run = '0;
				end else begin
					run = run + 1'b1;
					if (run == count) begin
						found = 1'b1;
						pos   = prba_pkg::SB_W'(k);
					end
				end
			end
		end
		res.found = found;
		res.pos   = pos;
		res.run   = run;
	end

endmodule

// ===== rtl/page_run_bitmap_allocator.sv =====
// channel   dir  handshake           payload
// s_*       in   s_tvalid/s_tready   s_tuser {pool_select, kind}, s_tdata {start_address, page_count}
// m_*       out  m_tvalid/m_tready   m_tdata {run_address, status}
// apb       in   psel/penable        4 registers at 4*i, pready tied high
//
// One transaction at a time. Free: check, decide, then a read-modify-write of each bitmap word
// touched; a rejected request goes from decide to the response. Allocate: check, decide, then
// a scan of each 64-page word (one RAM read, then 8 pages a cycle through the scan step), then
// a mark of each word of the run; when no run fits it responds after the scan. After reset a
// clearing pass writes both bitmaps; s_tready stays low meanwhile.
// A result waiting on m_tready does not block the next accept; it holds only the finish.
module page_run_bitmap_allocator #(
	parameter int POOL_PAGES = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [12:0] page_count, [44:13] start_address, [47:45] zero
	input  logic [prba_pkg::IN_DATA_W-1:0]  s_tdata,
	// [0] kind, [1] pool_select
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [1:0] status, [33:2] run_address, [39:34] zero
	output logic [prba_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [3:0]                      paddr,
	input  logic [31:0]                     pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	localparam int WORDS     = (POOL_PAGES + prba_pkg::WORD_BITS - 1) / prba_pkg::WORD_BITS;
	localparam int WA_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int IDX_W     = WA_W + prba_pkg::WB_W;
	localparam int SZ_W      = $clog2(POOL_PAGES + 1);
	localparam int RAM_AW    = WA_W + 1;
	localparam int RAM_DEPTH = 2 ** RAM_AW;
	localparam int BY_W      = prba_pkg::WB_W - prba_pkg::SB_W;
	localparam int ADDR_W    = prba_pkg::ADDR_W;
	localparam int COUNT_W   = prba_pkg::COUNT_W;
	localparam int OUT_PAD   = prba_pkg::OUT_DATA_W - ADDR_W - 2;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_DECIDE,
		S_SCAN_RD,
		S_SCAN,
		S_MARK_RD,
		S_MARK_WR,
		S_RESP
	} state_t;

	// configuration
	logic [prba_pkg::FRAME_W-1:0] pool0_base_q, pool1_base_q;
	logic [COUNT_W-1:0]           pool0_count_q, pool1_count_q;
	logic                         cfg_wr;
	prba_pkg::reg_idx_t           reg_sel;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_sel = prba_pkg::reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool0_base_q  <= '0;
			pool1_base_q  <= '0;
			pool0_count_q <= COUNT_W'(prba_pkg::COUNT_RESET);
			pool1_count_q <= COUNT_W'(prba_pkg::COUNT_RESET);
		end else if (cfg_wr) begin
			unique case (reg_sel)
				prba_pkg::REG_POOL0_BASE:  pool0_base_q  <= pwdata[prba_pkg::FRAME_W-1:0];
				prba_pkg::REG_POOL1_BASE:  pool1_base_q  <= pwdata[prba_pkg::FRAME_W-1:0];
				prba_pkg::REG_POOL0_COUNT: pool0_count_q <= pwdata[COUNT_W-1:0];
				prba_pkg::REG_POOL1_COUNT: pool1_count_q <= pwdata[COUNT_W-1:0];
				default:                   pool0_base_q  <= pool0_base_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_sel)
			prba_pkg::REG_POOL0_BASE:  prdata = 32'(pool0_base_q);
			prba_pkg::REG_POOL1_BASE:  prdata = 32'(pool1_base_q);
			prba_pkg::REG_POOL0_COUNT: prdata = 32'(pool0_count_q);
			prba_pkg::REG_POOL1_COUNT: prdata = 32'(pool1_count_q);
			default:                   prdata = '0;
		endcase
	end

	// sequencer state
	state_t                         state_q;
	prba_pkg::kind_t                kind_q;
	logic                           pool_q;
	logic [COUNT_W-1:0]             count_q;
	logic [ADDR_W-1:0]              addr_q;
	logic [SZ_W-1:0]                size_q;
	logic [ADDR_W-1:0]              base_q;
	logic                           bad_q;
	logic                           below_q;
	logic [ADDR_W-1:0]              diff_q;
	logic [WA_W-1:0]                word_idx_q;
	logic [BY_W-1:0]                byte_q;
	logic [SZ_W-1:0]                left_q;
	logic [COUNT_W-1:0]             run_q;
	logic [IDX_W-1:0]               run_lo_q, run_hi_q;
	logic [WA_W-1:0]                mw_q;
	logic                           set_q;
	prba_pkg::status_t              status_q;
	logic [ADDR_W-1:0]              result_q;
	logic [RAM_AW-1:0]              clr_q;
	logic                           m_tvalid_q;
	logic [prba_pkg::OUT_DATA_W-1:0] m_data_q;

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_data_q;

	// pool selection
	logic [COUNT_W-1:0]           sel_count;
	logic [prba_pkg::FRAME_W-1:0] sel_frame;
	logic [SZ_W-1:0]              sel_size;
	logic [ADDR_W-1:0]            sel_base;

	assign sel_count = pool_q ? pool1_count_q : pool0_count_q;
	assign sel_frame = pool_q ? pool1_base_q : pool0_base_q;
	assign sel_size  = (32'(sel_count) > 32'(POOL_PAGES)) ? SZ_W'(POOL_PAGES) : SZ_W'(sel_count);
	assign sel_base  = ADDR_W'({sel_frame, {prba_pkg::PAGE_SHIFT{1'b0}}});

	logic [ADDR_W-1:0] free_idx, free_end;
	logic              free_over;

	assign free_idx  = diff_q >> prba_pkg::PAGE_SHIFT;
	assign free_end  = free_idx + ADDR_W'(count_q);
	assign free_over = free_end > ADDR_W'(size_q);

	// scan step
	logic [prba_pkg::STEP_BITS-1:0] lane_en;
	logic [prba_pkg::WORD_BITS-1:0] rd_data;
	logic [prba_pkg::STEP_BITS-1:0] lane_bits;
	prba_pkg::scan_res_t            scan_res;
	logic [IDX_W-1:0]               found_idx, alloc_lo;

	always_comb begin
		for (int k = 0; k < prba_pkg::STEP_BITS; k++) begin
			lane_en[k] = left_q > SZ_W'(k);
		end
	end

	assign lane_bits = rd_data[{byte_q, {prba_pkg::SB_W{1'b0}}} +: prba_pkg::STEP_BITS];

	prba_scan u_scan (
		.lane_bits (lane_bits),
		.lane_en   (lane_en),
		.run_in    (run_q),
		.count     (count_q),
		.res       (scan_res)
	);

	assign found_idx = {word_idx_q, byte_q, scan_res.pos};
	assign alloc_lo  = IDX_W'(ADDR_W'(found_idx) + ADDR_W'(1) - ADDR_W'(count_q));

	// run mask for read-modify-write
	logic [WA_W-1:0]                lo_word, hi_word;
	logic [prba_pkg::WB_W-1:0]      lo_off, hi_off;
	logic [prba_pkg::WORD_BITS-1:0] mark_mask;

	assign lo_word   = run_lo_q[IDX_W-1:prba_pkg::WB_W];
	assign hi_word   = run_hi_q[IDX_W-1:prba_pkg::WB_W];
	assign lo_off    = (mw_q == lo_word) ? run_lo_q[prba_pkg::WB_W-1:0] : '0;
	assign hi_off    = (mw_q == hi_word) ? run_hi_q[prba_pkg::WB_W-1:0] : '1;
	assign mark_mask = ({prba_pkg::WORD_BITS{1'b1}} << lo_off)
		& ({prba_pkg::WORD_BITS{1'b1}} >> (prba_pkg::WB_W'(prba_pkg::WORD_BITS - 1) - hi_off));

	// bitmap RAM, pool in the top address bit
	logic                           wr_en;
	logic [RAM_AW-1:0]              wr_addr, rd_addr;
	logic [prba_pkg::WORD_BITS-1:0] wr_data;

	assign wr_en   = (state_q == S_CLEAR) || (state_q == S_MARK_WR);
	assign wr_addr = (state_q == S_CLEAR) ? clr_q : {pool_q, mw_q};
	assign wr_data = (state_q == S_CLEAR) ? '0
		: (set_q ? (rd_data | mark_mask) : (rd_data & ~mark_mask));

	always_comb begin
		unique case (state_q)
			S_MARK_RD: rd_addr = {pool_q, mw_q};
			S_MARK_WR: rd_addr = {pool_q, mw_q + 1'b1};
			default:   rd_addr = {pool_q, word_idx_q};
		endcase
	end

	prba_ram #(
		.WIDTH (prba_pkg::WORD_BITS),
		.DEPTH (RAM_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			m_tvalid_q <= 1'b0;
			word_idx_q <= '0;
			byte_q     <= '0;
			left_q     <= '0;
			run_q      <= '0;
			mw_q       <= '0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != S_RESP)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						kind_q  <= prba_pkg::kind_t'(s_tuser[0]);
						pool_q  <= s_tuser[1];
						count_q <= s_tdata[COUNT_W-1:0];
						addr_q  <= s_tdata[COUNT_W +: ADDR_W];
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					size_q  <= sel_size;
					base_q  <= sel_base;
					bad_q   <= (count_q == '0) || (32'(count_q) > 32'(sel_size));
					below_q <= addr_q < sel_base;
					diff_q  <= addr_q - sel_base;
					state_q <= S_DECIDE;
				end
				S_DECIDE: begin
					result_q <= '0;
					status_q <= prba_pkg::ST_OK;
					if (bad_q) begin
						status_q <= prba_pkg::ST_BADCOUNT;
						state_q  <= S_RESP;
					end else if (kind_q == prba_pkg::KIND_ALLOC) begin
						word_idx_q <= '0;
						byte_q     <= '0;
						left_q     <= size_q;
						run_q      <= '0;
						state_q    <= S_SCAN_RD;
					end else if (below_q || free_over) begin
						status_q <= prba_pkg::ST_OUTSIDE;
						state_q  <= S_RESP;
					end else begin
						run_lo_q <= free_idx[IDX_W-1:0];
						run_hi_q <= IDX_W'(free_end - 1'b1);
						mw_q     <= free_idx[IDX_W-1:prba_pkg::WB_W];
						set_q    <= 1'b0;
						state_q  <= S_MARK_RD;
					end
				end
				S_SCAN_RD: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (scan_res.found) begin
						run_lo_q <= alloc_lo;
						run_hi_q <= found_idx;
						mw_q     <= alloc_lo[IDX_W-1:prba_pkg::WB_W];
						set_q    <= 1'b1;
						state_q  <= S_MARK_RD;
					end else if (left_q <= SZ_W'(prba_pkg::STEP_BITS)) begin
						status_q <= prba_pkg::ST_NOSPACE;
						state_q  <= S_RESP;
					end else begin
						left_q <= left_q - SZ_W'(prba_pkg::STEP_BITS);
						run_q  <= scan_res.run;
						byte_q <= byte_q + 1'b1;
						if (&byte_q) begin
							word_idx_q <= word_idx_q + 1'b1;
							state_q    <= S_SCAN_RD;
						end
					end
				end
				S_MARK_RD: begin
					state_q <= S_MARK_WR;
				end
				S_MARK_WR: begin
					if (mw_q == hi_word) begin
						if (set_q) begin
							result_q <= base_q + (ADDR_W'(run_lo_q) << prba_pkg::PAGE_SHIFT);
						end
						state_q <= S_RESP;
					end else begin
						mw_q <= mw_q + 1'b1;
					end
				end
				S_RESP: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_data_q   <= {{OUT_PAD{1'b0}}, result_q, status_q};
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	a_mark_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK_WR) |-> (mw_q >= lo_word) && (mw_q <= hi_word))
		else $error("bitmap sweep outside run");

	a_run_in_pool: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MARK_RD) |-> (run_lo_q <= run_hi_q) && (32'(run_hi_q) < 32'(size_q)))
		else $error("run outside pool");

	a_scan_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (left_q != '0))
		else $error("scan past pool end");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && m_tvalid_q && !m_tready) |=> (state_q == S_RESP))
		else $error("result overwrote pending transaction");

endmodule
